// File: hdl/obfn_pkg.sv
// ----------------------------------------------------------------------------
// obfn_pkg : shared types and constants
// widths and pipeline stage numbering for the orthonormal basis block
// ----------------------------------------------------------------------------
package obfn_pkg;

   localparam int COMP_WIDTH = 16;

   // one in fixed point and the largest magnitude that is kept
   localparam logic [COMP_WIDTH-1:0] ONE_Q = COMP_WIDTH'(1) << (COMP_WIDTH - 1);
   localparam logic [COMP_WIDTH-1:0] MAX_Q = ONE_Q - COMP_WIDTH'(1);

   // squared length of the raw tangent, at most three squares below 2^(2w-2)
   localparam int LEN_W = 2 * COMP_WIDTH;
   // residual of the root recurrence, signed
   localparam int RES_W = 4 * COMP_WIDTH + 4;

   // stage numbering
   localparam int S_INIT     = 2;
   localparam int S_REC0     = 3;
   localparam int S_C1       = S_REC0 + COMP_WIDTH;
   localparam int NUM_STAGES = S_C1 + 2;

   localparam int IN_TDATA_W  = ((3 * COMP_WIDTH + 7) / 8) * 8;
   localparam int OUT_TDATA_W = ((6 * COMP_WIDTH + 7) / 8) * 8;

   typedef logic signed [COMP_WIDTH-1:0] comp_type;
   typedef logic [NUM_STAGES-1:0]        stage_vec_type;

endpackage

// File: hdl/obfn_front.sv
// ----------------------------------------------------------------------------
// obfn_front : axis choice and raw tangent
// clamps the normal, picks the smallest axis, forms e x n and its squares
// ----------------------------------------------------------------------------
module obfn_front
   import obfn_pkg::*;
(
   input  logic                  clock,
   input  logic [1:0]            en,
   input  comp_type              n_in [3],
   output comp_type              n_out [3],
   output logic [2*COMP_WIDTH-1:0] sq_out [3],
   output logic [2:0]            neg_out,
   output logic [LEN_W-1:0]      len_out
);

   comp_type                n_c [3];
   logic [COMP_WIDTH-1:0]   a_c [3];
   comp_type                t_c [3];
   comp_type                n_ff [3];
   comp_type                t_ff [3];
   logic [COMP_WIDTH-1:0]   mag_c [3];
   logic [2*COMP_WIDTH-1:0] sq_ff [3];
   logic [2:0]              neg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // most negative code is taken as -(one-1)
         if (n_in[i] == $signed(ONE_Q)) begin
            n_c[i] = -$signed(MAX_Q);
         end else begin
            n_c[i] = n_in[i];
         end
         a_c[i] = n_c[i][COMP_WIDTH-1] ? COMP_WIDTH'(-n_c[i]) : COMP_WIDTH'(n_c[i]);
      end
      // ties go to the later axis
      if (a_c[0] < a_c[1] && a_c[0] < a_c[2]) begin
         t_c[0] = '0;
         t_c[1] = -n_c[2];
         t_c[2] = n_c[1];
      end else if (a_c[0] >= a_c[1] && a_c[1] < a_c[2]) begin
         t_c[0] = n_c[2];
         t_c[1] = '0;
         t_c[2] = -n_c[0];
      end else begin
         t_c[0] = -n_c[1];
         t_c[1] = n_c[0];
         t_c[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         n_ff <= n_c;
         t_ff <= t_c;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_c[i] = t_ff[i][COMP_WIDTH-1] ? COMP_WIDTH'(-t_ff[i]) : COMP_WIDTH'(t_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]  <= mag_c[i] * mag_c[i];
            neg_ff[i] <= t_ff[i][COMP_WIDTH-1];
         end
      end
   end

   assign n_out   = n_ff;
   assign sq_out  = sq_ff;
   assign neg_out = neg_ff;
   assign len_out = LEN_W'(sq_ff[0] + sq_ff[1] + sq_ff[2]);

endmodule

// File: hdl/obfn_rsqrt_lane.sv
// ----------------------------------------------------------------------------
// obfn_rsqrt_lane : one tangent component scaled to unit length
// pipelined digit recurrence, one result bit per stage, rounded to nearest
// ----------------------------------------------------------------------------
module obfn_rsqrt_lane
   import obfn_pkg::*;
(
   input  logic                    clock,
   input  logic [COMP_WIDTH:0]     en,
   input  logic [2*COMP_WIDTH-1:0] sq,
   input  logic [LEN_W-1:0]        len,
   input  logic                    neg,
   output comp_type                t1
);

   logic signed [RES_W-1:0] r_ff   [COMP_WIDTH+1];
   logic signed [RES_W-1:0] p_ff   [COMP_WIDTH+1];
   logic [COMP_WIDTH-1:0]   q_ff   [COMP_WIDTH+1];
   logic [LEN_W-1:0]        l_ff   [COMP_WIDTH+1];
   logic                    neg_ff [COMP_WIDTH+1];
   logic [COMP_WIDTH-1:0]   q_sat;

   // residual holds mag^2 * 2^(2w) - (2q-1)^2 * len, p holds (2q-1) * len
   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]   <= (RES_W'(sq) << (2 * COMP_WIDTH)) - RES_W'(len);
         p_ff[0]   <= -$signed(RES_W'(len));
         q_ff[0]   <= '0;
         l_ff[0]   <= len;
         neg_ff[0] <= neg;
      end
   end

   for (genvar k = 0; k < COMP_WIDTH; k++) begin : g_bit
      localparam int B = COMP_WIDTH - 1 - k;
      logic signed [RES_W-1:0] trial;
      logic signed [RES_W-1:0] r_new;
      logic                    take;

      always_comb begin
         trial = (p_ff[k] <<< (B + 2)) + $signed(RES_W'(l_ff[k]) << (2 * B + 2));
         r_new = r_ff[k] - trial;
         // once the bit for one is set no larger value is tried
         take  = !r_new[RES_W-1] && !q_ff[k][COMP_WIDTH-1];
      end

      always_ff @(posedge clock) begin
         if (en[k+1]) begin
            l_ff[k+1]   <= l_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            if (take) begin
               r_ff[k+1] <= r_new;
               p_ff[k+1] <= p_ff[k] + $signed(RES_W'(l_ff[k]) << (B + 1));
               q_ff[k+1] <= q_ff[k] | (COMP_WIDTH'(1) << B);
            end else begin
               r_ff[k+1] <= r_ff[k];
               p_ff[k+1] <= p_ff[k];
               q_ff[k+1] <= q_ff[k];
            end
         end
      end
   end

   assign q_sat = (q_ff[COMP_WIDTH] > MAX_Q) ? MAX_Q : q_ff[COMP_WIDTH];
   assign t1    = neg_ff[COMP_WIDTH] ? -$signed(q_sat) : $signed(q_sat);

endmodule

// File: hdl/obfn_cross.sv
// ----------------------------------------------------------------------------
// obfn_cross : second tangent as n x t1
// products in one stage, difference, rounding and saturation in the next
// ----------------------------------------------------------------------------
module obfn_cross
   import obfn_pkg::*;
(
   input  logic     clock,
   input  logic [1:0] en,
   input  comp_type n [3],
   input  comp_type t1_in [3],
   input  logic     deg_in,
   output comp_type t1_out [3],
   output comp_type t2_out [3],
   output logic     deg_out
);

   logic signed [2*COMP_WIDTH-1:0] pa_ff [3];
   logic signed [2*COMP_WIDTH-1:0] pb_ff [3];
   comp_type                       t1_ff [3];
   logic                           deg_ff;
   comp_type                       t1_o_ff [3];
   comp_type                       t2_o_ff [3];
   logic                           deg_o_ff;
   logic signed [2*COMP_WIDTH:0]   d_c [3];
   logic [2*COMP_WIDTH:0]          m_c [3];
   logic [2*COMP_WIDTH:0]          q_c [3];
   comp_type                       t2_c [3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= n[(i+1)%3] * t1_in[(i+2)%3];
            pb_ff[i] <= n[(i+2)%3] * t1_in[(i+1)%3];
         end
         t1_ff  <= t1_in;
         deg_ff <= deg_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_c[i] = (2*COMP_WIDTH+1)'(pa_ff[i]) - (2*COMP_WIDTH+1)'(pb_ff[i]);
         m_c[i] = d_c[i][2*COMP_WIDTH] ? (2*COMP_WIDTH+1)'(-d_c[i]) : (2*COMP_WIDTH+1)'(d_c[i]);
         // halves away from zero
         q_c[i] = (m_c[i] + ((2*COMP_WIDTH+1)'(1) << (COMP_WIDTH - 2))) >> (COMP_WIDTH - 1);
         if (q_c[i] > (2*COMP_WIDTH+1)'(MAX_Q)) begin
            q_c[i] = (2*COMP_WIDTH+1)'(MAX_Q);
         end
         t2_c[i] = d_c[i][2*COMP_WIDTH] ? -$signed(q_c[i][COMP_WIDTH-1:0])
                                        : $signed(q_c[i][COMP_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            t1_o_ff[i] <= deg_ff ? '0 : t1_ff[i];
            t2_o_ff[i] <= deg_ff ? '0 : t2_c[i];
         end
         deg_o_ff <= deg_ff;
      end
   end

   assign t1_out  = t1_o_ff;
   assign t2_out  = t2_o_ff;
   assign deg_out = deg_o_ff;

endmodule

// File: hdl/orthonormal_basis_from_normal.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_from_normal : tangent frame from a unit normal
// builds t1 = e x n scaled to unit length and t2 = n x t1, in q1.15
//
//   channel | direction | payload
//   req_    | in        | tdata: n_x, n_y, n_z
//   rsp_    | out       | tdata: t1_x..t2_z, tuser: degenerate
//
// one request per cycle sustained unless a stalled response backs up the stages;
// the depth is set by the root recurrence that resolves one bit of each t1 component per stage
// reset clears only the stage valid bits, data registers are not reset
// each stage holds while the next is full and held, so a stalled response lets
// empty stages upstream keep filling and nothing is lost or repeated
// ----------------------------------------------------------------------------
module orthonormal_basis_from_normal
   import obfn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_TDATA_W-1:0]  req_tdata,   // n_x, n_y, n_z
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_TDATA_W-1:0] rsp_tdata,   // t1_x, t1_y, t1_z, t2_x, t2_y, t2_z
   output logic                   rsp_tuser    // degenerate
);

   stage_vec_type           valid_ff;
   stage_vec_type           valid_in;
   stage_vec_type           en;
   comp_type                n_req [3];
   comp_type                n_front [3];
   logic [2*COMP_WIDTH-1:0] sq [3];
   logic [2:0]              neg;
   logic [LEN_W-1:0]        len;
   comp_type                n_dly_ff [1:S_C1-1][3];
   logic                    deg_dly_ff [S_INIT:S_C1-1];
   comp_type                t1 [3];
   comp_type                t1_o [3];
   comp_type                t2_o [3];
   logic                    deg_o;

   // a stage may load when it is empty or its item moves on
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int s = 1; s < NUM_STAGES; s++) begin
         valid_in[s] = en[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign n_req[i] = req_tdata[i*COMP_WIDTH +: COMP_WIDTH];
   end

   obfn_front u_front (
      .clock   (clock),
      .en      (en[1:0]),
      .n_in    (n_req),
      .n_out   (n_front),
      .sq_out  (sq),
      .neg_out (neg),
      .len_out (len)
   );

   // the normal rides alongside the recurrence
   always_ff @(posedge clock) begin
      if (en[1]) begin
         n_dly_ff[1] <= n_front;
      end
      for (int s = 2; s < S_C1; s++) begin
         if (en[s]) begin
            n_dly_ff[s] <= n_dly_ff[s-1];
         end
      end
   end

   // zero length happens only for a zero normal
   always_ff @(posedge clock) begin
      if (en[S_INIT]) begin
         deg_dly_ff[S_INIT] <= (len == '0);
      end
      for (int s = S_INIT + 1; s < S_C1; s++) begin
         if (en[s]) begin
            deg_dly_ff[s] <= deg_dly_ff[s-1];
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      obfn_rsqrt_lane u_lane (
         .clock (clock),
         .en    (en[S_INIT +: COMP_WIDTH+1]),
         .sq    (sq[i]),
         .len   (len),
         .neg   (neg[i]),
         .t1    (t1[i])
      );
   end

   obfn_cross u_cross (
      .clock   (clock),
      .en      (en[S_C1 +: 2]),
      .n       (n_dly_ff[S_C1-1]),
      .t1_in   (t1),
      .deg_in  (deg_dly_ff[S_C1-1]),
      .t1_out  (t1_o),
      .t2_out  (t2_o),
      .deg_out (deg_o)
   );

   assign rsp_tdata = OUT_TDATA_W'({t2_o[2], t2_o[1], t2_o[0], t1_o[2], t1_o[1], t1_o[0]});
   assign rsp_tuser = deg_o;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : testbench for orthonormal_basis_from_normal
// streams normals through the block with random idling on both sides and
// checks every tangent pair against a behavioural predictor in order
// ----------------------------------------------------------------------------
module tb_top
   import obfn_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] t1x, t1y, t1z, t2x, t2y, t2z;
      logic               degen;
   } frame_type;

   // tangent frame expected for one normal
   function automatic frame_type frame_of(logic [47:0] nv);
      frame_type          f;
      longint             n [3];
      longint             t [3];
      longint             len2, m, rhi, q, cand, odd;
      longint unsigned    lhs, rhs;
      longint             s [3];
      for (int i = 0; i < 3; i++) begin
         n[i] = longint'($signed(nv[16*i +: 16]));
         if (n[i] < -32767) n[i] = -32767;
      end
      if ((n[0] < 0 ? -n[0] : n[0]) < (n[1] < 0 ? -n[1] : n[1])) begin
         if ((n[0] < 0 ? -n[0] : n[0]) < (n[2] < 0 ? -n[2] : n[2])) begin
            t[0] = 0; t[1] = -n[2]; t[2] = n[1];
         end else begin
            t[0] = -n[1]; t[1] = n[0]; t[2] = 0;
         end
      end else if ((n[1] < 0 ? -n[1] : n[1]) < (n[2] < 0 ? -n[2] : n[2])) begin
         t[0] = n[2]; t[1] = 0; t[2] = -n[0];
      end else begin
         t[0] = -n[1]; t[1] = n[0]; t[2] = 0;
      end
      len2 = t[0]*t[0] + t[1]*t[1] + t[2]*t[2];
      f = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0};
      if (len2 == 0) begin
         f.degen = 1'b1;
         return f;
      end
      // largest q with (2q-1)^2 * len2 <= 4 * c^2 * one^2, i.e. rounded scale
      for (int i = 0; i < 3; i++) begin
         m = t[i] < 0 ? -t[i] : t[i];
         rhi = m * m;
         q = 0;
         for (int b = 15; b >= 0; b--) begin
            cand = q | (64'sd1 << b);
            if (cand > 32768) continue;
            odd = 2*cand - 1;
            lhs = longint'(odd*odd) * len2;  // below 2^63 for these widths
            rhs = longint'(rhi) << 32;
            if (lhs <= rhs) q = cand;
         end
         if (q > 32767) q = 32767;
         t[i] = t[i] < 0 ? -q : q;
      end
      s[0] = n[1]*t[2] - n[2]*t[1];
      s[1] = n[2]*t[0] - n[0]*t[2];
      s[2] = n[0]*t[1] - n[1]*t[0];
      for (int i = 0; i < 3; i++) begin
         m = s[i] < 0 ? -s[i] : s[i];
         q = (m + 16384) >>> 15;
         if (q > 32767) q = 32767;
         s[i] = s[i] < 0 ? -q : q;
      end
      f.t1x = 16'(t[0]); f.t1y = 16'(t[1]); f.t1z = 16'(t[2]);
      f.t2x = 16'(s[0]); f.t2y = 16'(s[1]); f.t2z = 16'(s[2]);
      return f;
   endfunction

   class frame_board;
      frame_type pending [$];
      int        errors;

      function void note_normal(logic [47:0] nv);
         pending.push_back(frame_of(nv));
      endfunction

      function void check_frame(logic [95:0] d, logic u);
         frame_type e;
         logic [15:0] got [6];
         logic [15:0] exp_v [6];
         if (pending.size() == 0) begin
            $display("%0t: unexpected response tdata=%h tuser=%b", $time, d, u);
            errors++;
            return;
         end
         e = pending.pop_front();
         exp_v = '{e.t1x, e.t1y, e.t1z, e.t2x, e.t2y, e.t2z};
         for (int i = 0; i < 6; i++) begin
            got[i] = d[16*i +: 16];
            if (got[i] !== exp_v[i]) begin
               $display("%0t: field %0d expected %h actual %h", $time, i, exp_v[i], got[i]);
               errors++;
            end
         end
         if (u !== e.degen) begin
            $display("%0t: degenerate expected %b actual %b", $time, e.degen, u);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata;   // n_x, n_y, n_z
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [OUT_TDATA_W-1:0] rsp_tdata;   // t1_x, t1_y, t1_z, t2_x, t2_y, t2_z
   logic                   rsp_tuser;   // degenerate

   frame_board board = new();
   bit         calm;      // no idling in the closing stretch
   bit         hold_rsp;  // long receiver hold-off

   orthonormal_basis_from_normal DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit well past the slowest legal run
   initial begin
      #5ms;
      $display("** orthonormal_basis_from_normal: FAILED **");
      $finish;
   end

   // send one normal, holding tdata until the block takes it
   task automatic send_normal(logic [47:0] nv);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= nv;
      do @(posedge clock); while (!req_tready);
      board.note_normal(nv);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'($signed($urandom_range(0, 8)) - 4);
         default: return 16'($urandom());
      endcase
   endfunction

   // roughly unit normal with random signs and a random rotation of its components
   function automatic logic [47:0] rand_unit();
      int  a, b, c;
      real rem;
      a = $urandom_range(0, 32767);
      b = int'($sqrt(real'(32767.0 * 32767.0 - real'(a) * a)) * $urandom_range(0, 1000) / 1000.0);
      rem = 32767.0 * 32767.0 - real'(a) * a - real'(b) * b;
      if (rem < 0.0) rem = 0.0;
      c = int'($sqrt(rem));
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
      if ($urandom_range(0, 1)) c = -c;
      case ($urandom_range(0, 2))
         0:       return {16'(c), 16'(b), 16'(a)};
         1:       return {16'(a), 16'(c), 16'(b)};
         default: return {16'(b), 16'(a), 16'(c)};
      endcase
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (120) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_frame(rsp_tdata[95:0], rsp_tuser);

   logic [47:0] directed [$];
   int          guard;

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      calm       = 1'b0;
      hold_rsp   = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // axis picks, ties, extremes, most negative, zero vector, non-unit
      directed = '{48'h0,
                   {16'h0, 16'h0, 16'h7fff}, {16'h0, 16'h7fff, 16'h0},
                   {16'h7fff, 16'h0, 16'h0}, {16'h0, 16'h0, 16'h8001},
                   {16'h8000, 16'h8000, 16'h8000}, {16'h7fff, 16'h7fff, 16'h7fff},
                   {16'h4000, 16'h4000, 16'h0}, {16'h0, 16'h4000, 16'h4000},
                   {16'h4000, 16'h0, 16'h4000}, {16'h0, 16'h0, 16'h0001},
                   {16'h0001, 16'hffff, 16'h0001}, {16'h5a82, 16'ha57e, 16'h0},
                   {16'h49e7, 16'h49e7, 16'h49e7}, {16'h8001, 16'h7fff, 16'h0001},
                   {16'h0010, 16'h7ffe, 16'h0200}, {16'hffff, 16'hffff, 16'hffff},
                   {16'h0, 16'h0001, 16'h0}, {16'h8000, 16'h0, 16'h0}};
      foreach (directed[i]) send_normal(directed[i]);

      // sender keeps offering while the receiver holds off, so the pipe fills
      hold_rsp = 1'b1;
      for (int i = 0; i < 60; i++) send_normal(rand_unit());

      // sender pause until every frame has come back
      req_tvalid <= 1'b0;
      guard = 0;
      while (board.pending.size() != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end

      for (int i = 0; i < 720; i++) begin
         if (i == 620) calm = 1'b1;
         if ($urandom_range(0, 3) == 0)
            send_normal({rand_comp(), rand_comp(), rand_comp()});
         else
            send_normal(rand_unit());
      end
      req_tvalid <= 1'b0;

      guard = 0;
      while (board.pending.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (40) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("** orthonormal_basis_from_normal: PASSED **");
      else
         $display("** orthonormal_basis_from_normal: FAILED **");
      $finish;
   end

endmodule

// File: files.f
hdl/obfn_pkg.sv
hdl/obfn_front.sv
hdl/obfn_rsqrt_lane.sv
hdl/obfn_cross.sv
hdl/orthonormal_basis_from_normal.sv
tb/sv/tb_top.sv
